/* hw/rtl/pkpc_pkg.sv */
package pkpc_pkg;

	localparam int TIMER_W = 16;
	localparam int HELD_W  = 16;
	localparam int ADDR_W  = 4;

	localparam logic [7:0]  DEBOUNCE_RST = 8'd20;
	localparam logic [15:0] LONG_RST     = 16'd2500;
	localparam logic [15:0] TIMEOUT_RST  = 16'd5000;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_TIMEOUT  = 2'd2,
		REG_WAKE     = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_DEBOUNCE = 3'd1,
		MODE_PRESS    = 3'd2,
		MODE_LONG     = 3'd3,
		MODE_SLEEP    = 3'd4,
		MODE_CONFIRM  = 3'd5,
		MODE_WAITREL  = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_BOUNCE    = 4'd1,
		EV_ACCEPTED  = 4'd2,
		EV_SHORT     = 4'd3,
		EV_PERIPH    = 4'd4,
		EV_SLEEP     = 4'd5,
		EV_WAKE      = 4'd6,
		EV_CONFIRMED = 4'd7,
		EV_FAIL      = 4'd8,
		EV_TIMEOUT   = 4'd9,
		EV_UNARMED   = 4'd10
	} event_t;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [15:0] long_press_ticks;
		logic [15:0] confirm_timeout_ticks;
		logic        start_from_wake;
		logic        restart;
	} cfg_t;

endpackage

/* hw/rtl/power_key_press_classifier.sv */
// Latency: a request accepted at one edge shows its result in the output register
// at that same edge, visible the following cycle.
// Throughput: one request per cycle; s_tready stays high while the output register
// is empty or being drained.
// Reset: arst_n clears the output valid flag and loads the run-idle (armed) state;
// writing start_from_wake reloads the start state under the new value.
module power_key_press_classifier import pkpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] button_level, [7:1] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [3:0] event_code, [19:4] held_ticks, [20] asleep
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic [TIMER_W-1:0] TMAX = {TIMER_W{1'b1}};

	cfg_t               cfg;
	mode_t              mode_q, mode_n;
	logic [TIMER_W-1:0] ptmr_q, ptmr_n;
	logic [TIMER_W-1:0] ctmr_q, ctmr_n;
	logic               armed_q, armed_n;
	logic               m_valid_q;
	logic [23:0]        m_data_q;
	logic               accept;
	logic               b;
	logic               resample;
	event_t             ev;
	logic [HELD_W-1:0]  held;
	logic [TIMER_W-1:0] long_t, deb_t, tmo_t;

	pkpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign b        = s_tdata[0];
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign long_t = TIMER_W'(cfg.long_press_ticks);
	assign deb_t  = TIMER_W'(cfg.debounce_ticks);
	assign tmo_t  = TIMER_W'(cfg.confirm_timeout_ticks);

	always_comb begin
		mode_n   = mode_q;
		ptmr_n   = ptmr_q;
		ctmr_n   = ctmr_q;
		armed_n  = armed_q;
		ev       = EV_NONE;
		resample = 1'b0;

		unique case (mode_q)
			MODE_DEBOUNCE: begin
				ptmr_n   = (ptmr_q == TMAX) ? TMAX : ptmr_q + 1'b1;
				resample = ptmr_n >= deb_t;
			end
			MODE_PRESS: begin
				ptmr_n = (ptmr_q == TMAX) ? TMAX : ptmr_q + 1'b1;
				if (!b) begin
					ev      = EV_SHORT;
					armed_n = 1'b1;
					mode_n  = MODE_IDLE;
				end else if (ptmr_n >= long_t) begin
					ev     = EV_PERIPH;
					mode_n = MODE_LONG;
				end
			end
			MODE_LONG: begin
				ptmr_n = (ptmr_q == TMAX) ? TMAX : ptmr_q + 1'b1;
				if (!b) begin
					ev      = EV_SLEEP;
					armed_n = 1'b1;
					mode_n  = MODE_SLEEP;
				end
			end
			MODE_SLEEP: begin
				ptmr_n = '0;
				if (b) begin
					ev      = EV_WAKE;
					ctmr_n  = '0;
					armed_n = 1'b0;
					mode_n  = MODE_CONFIRM;
				end
			end
			MODE_CONFIRM: begin
				ctmr_n = (ctmr_q == TMAX) ? TMAX : ctmr_q + 1'b1;
				ptmr_n = (ptmr_q == TMAX) ? TMAX : ptmr_q + 1'b1;
				// timeout wins over the level
				if (ctmr_n >= tmo_t) begin
					ev     = EV_TIMEOUT;
					mode_n = MODE_SLEEP;
				end else if (!b) begin
					ev     = EV_FAIL;
					mode_n = MODE_SLEEP;
				end else if (ptmr_n >= long_t) begin
					ev     = EV_CONFIRMED;
					mode_n = MODE_WAITREL;
				end
			end
			MODE_WAITREL: begin
				if (!b) begin
					armed_n = 1'b1;
					mode_n  = MODE_IDLE;
					ptmr_n  = '0;
				end
			end
			default: begin
				// idle, and the spare code behaves as idle
				mode_n = MODE_IDLE;
				ptmr_n = '0;
				if (b) begin
					mode_n   = MODE_DEBOUNCE;
					resample = deb_t == '0;
				end else begin
					armed_n = 1'b1;
				end
			end
		endcase

		if (resample) begin
			priority if (!b) begin
				ev      = EV_BOUNCE;
				armed_n = 1'b1;
				mode_n  = MODE_IDLE;
			end else if (!armed_n) begin
				ev     = EV_UNARMED;
				mode_n = MODE_WAITREL;
			end else begin
				ev      = EV_ACCEPTED;
				armed_n = 1'b0;
				mode_n  = MODE_PRESS;
			end
		end

		held = HELD_W'((ptmr_n < long_t) ? ptmr_n : long_t);
		if ((mode_n == MODE_WAITREL || mode_n == MODE_IDLE) && ev == EV_NONE)
			held = '0;
		if (ev == EV_WAKE)
			held = '0;

		if (mode_n == MODE_IDLE || mode_n == MODE_SLEEP || mode_n == MODE_WAITREL)
			ptmr_n = '0;
		if (mode_n != MODE_CONFIRM)
			ctmr_n = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			ptmr_q  <= '0;
			ctmr_q  <= '0;
			armed_q <= 1'b1;
		end else if (cfg.restart) begin
			mode_q  <= cfg.start_from_wake ? MODE_CONFIRM : MODE_IDLE;
			ptmr_q  <= '0;
			ctmr_q  <= '0;
			armed_q <= !cfg.start_from_wake;
		end else if (accept) begin
			mode_q  <= mode_n;
			ptmr_q  <= ptmr_n;
			ctmr_q  <= ctmr_n;
			armed_q <= armed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {3'd0, mode_n == MODE_SLEEP, held, ev};
		end
	end

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output register");

	a_asleep_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.restart) |=> (m_tdata[20] == (mode_q == MODE_SLEEP)))
		else $error("asleep flag disagrees with mode");

	a_confirm_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_CONFIRM) |-> (ctmr_q == '0))
		else $error("confirm timer running outside wake-confirm");

	a_press_timer_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE || mode_q == MODE_SLEEP || mode_q == MODE_WAITREL)
		|-> (ptmr_q == '0))
		else $error("press timer not cleared while no press is timed");
`endif

endmodule

/* hw/rtl/pkpc_regs.sv */
module pkpc_regs import pkpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [7:0]  debounce_q;
	logic [15:0] long_q;
	logic [15:0] timeout_q;
	logic        wake_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_q     <= LONG_RST;
			timeout_q  <= TIMEOUT_RST;
			wake_q     <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE: debounce_q <= pwdata[7:0];
				REG_LONG:     long_q     <= pwdata[15:0];
				REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
				REG_WAKE:     wake_q     <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEBOUNCE: prdata = {24'd0, debounce_q};
			REG_LONG:     prdata = {16'd0, long_q};
			REG_TIMEOUT:  prdata = {16'd0, timeout_q};
			REG_WAKE:     prdata = {31'd0, wake_q};
		endcase
	end

	// restart is combinational so the state reloads on the same edge as the write
	assign cfg.debounce_ticks        = debounce_q;
	assign cfg.long_press_ticks      = long_q;
	assign cfg.confirm_timeout_ticks = timeout_q;
	assign cfg.start_from_wake       = wr_en && (idx == REG_WAKE) ? pwdata[0] : wake_q;
	assign cfg.restart               = wr_en && (idx == REG_WAKE);

endmodule

/* sim/tb_power_key_press_classifier.sv */
module tb_power_key_press_classifier;
	import pkpc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		event_t      ev;
		logic [15:0] held;
		logic        asleep;
	} key_event_t;

	// Tracks the classifier state and the events each button sample should produce.
	class press_scoreboard;
		logic [7:0]  debounce;
		logic [15:0] long_thr;
		logic [15:0] timeout_thr;
		logic        wake_start;
		mode_t       mode;
		logic [15:0] press_t;
		logic [15:0] confirm_t;
		logic        armed;
		key_event_t  pending[$];
		int          errors;

		function new();
			debounce    = DEBOUNCE_RST;
			long_thr    = LONG_RST;
			timeout_thr = TIMEOUT_RST;
			wake_start  = 1'b0;
			errors      = 0;
			restart();
		endfunction

		function void restart();
			press_t   = '0;
			confirm_t = '0;
			mode      = wake_start ? MODE_CONFIRM : MODE_IDLE;
			armed     = !wake_start;
		endfunction

		function logic [15:0] bump(logic [15:0] t);
			return (t == 16'hFFFF) ? t : t + 16'd1;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] word);
			case (idx)
				REG_DEBOUNCE: debounce = word[7:0];
				REG_LONG:     long_thr = word[15:0];
				REG_TIMEOUT:  timeout_thr = word[15:0];
				REG_WAKE: begin
					wake_start = word[0];
					restart();
				end
			endcase
		endfunction

		function void note_level(logic lvl);
			event_t      ev;
			logic [15:0] held;
			logic        resample;
			ev = EV_NONE;
			resample = 1'b0;
			case (mode)
				MODE_IDLE: begin
					press_t = '0;
					if (lvl) begin
						mode = MODE_DEBOUNCE;
						resample = (debounce == 8'd0);
					end else begin
						armed = 1'b1;
					end
				end
				MODE_DEBOUNCE: begin
					press_t = bump(press_t);
					resample = (press_t >= debounce);
				end
				MODE_PRESS: begin
					press_t = bump(press_t);
					if (!lvl) begin
						ev = EV_SHORT;
						armed = 1'b1;
						mode = MODE_IDLE;
					end else if (press_t >= long_thr) begin
						ev = EV_PERIPH;
						mode = MODE_LONG;
					end
				end
				MODE_LONG: begin
					press_t = bump(press_t);
					if (!lvl) begin
						ev = EV_SLEEP;
						armed = 1'b1;
						mode = MODE_SLEEP;
					end
				end
				MODE_SLEEP: begin
					press_t = '0;
					if (lvl) begin
						ev = EV_WAKE;
						confirm_t = '0;
						armed = 1'b0;
						mode = MODE_CONFIRM;
					end
				end
				MODE_CONFIRM: begin
					confirm_t = bump(confirm_t);
					press_t = bump(press_t);
					// timeout wins over the button level
					if (confirm_t >= timeout_thr) begin
						ev = EV_TIMEOUT;
						mode = MODE_SLEEP;
					end else if (!lvl) begin
						ev = EV_FAIL;
						mode = MODE_SLEEP;
					end else if (press_t >= long_thr) begin
						ev = EV_CONFIRMED;
						mode = MODE_WAITREL;
					end
				end
				default: begin
					if (!lvl) begin
						armed = 1'b1;
						mode = MODE_IDLE;
						press_t = '0;
					end
				end
			endcase

			if (resample) begin
				if (!lvl) begin
					ev = EV_BOUNCE;
					armed = 1'b1;
					mode = MODE_IDLE;
				end else if (!armed) begin
					ev = EV_UNARMED;
					mode = MODE_WAITREL;
				end else begin
					ev = EV_ACCEPTED;
					armed = 1'b0;
					mode = MODE_PRESS;
				end
			end

			held = (press_t < long_thr) ? press_t : long_thr;
			if ((mode == MODE_WAITREL || mode == MODE_IDLE) && ev == EV_NONE)
				held = '0;
			if (ev == EV_WAKE)
				held = '0;
			pending.push_back(key_event_t'{ev, held, mode == MODE_SLEEP});

			if (mode == MODE_IDLE || mode == MODE_SLEEP || mode == MODE_WAITREL)
				press_t = '0;
			if (mode != MODE_CONFIRM)
				confirm_t = '0;
		endfunction

		function void check_result(logic [23:0] data);
			key_event_t exp_ev;
			if (pending.size() == 0) begin
				$error("unexpected result event_code=%0d held_ticks=%0d asleep=%0d",
					data[3:0], data[19:4], data[20]);
				errors++;
				return;
			end
			exp_ev = pending.pop_front();
			if (data[3:0] !== exp_ev.ev) begin
				$error("event_code expected %0d actual %0d", exp_ev.ev, data[3:0]);
				errors++;
			end
			if (data[19:4] !== exp_ev.held) begin
				$error("held_ticks expected %0d actual %0d", exp_ev.held, data[19:4]);
				errors++;
			end
			if (data[20] !== exp_ev.asleep) begin
				$error("asleep expected %0d actual %0d", exp_ev.asleep, data[20]);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [23:0]       m_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	press_scoreboard sb = new();
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int items_sent = 0;
	int cycles = 0;

	power_key_press_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= rx_gaps ? ($urandom_range(0, 99) >= 33) : 1'b1;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("power_key_press_classifier: mismatch");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge with tvalid still up.
	task automatic send_level(input logic lvl);
		while (tx_gaps && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, lvl};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		sb.note_level(lvl);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic press_release(input int hold, input int rest);
		repeat (hold) send_level(1'b1);
		repeat (rest) send_level(1'b0);
	endtask

	// Hold off until every request has produced its event.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] mask;
		logic [31:0] word;
		case (idx)
			REG_DEBOUNCE: mask = 32'hFF;
			REG_WAKE:     mask = 32'h1;
			default:      mask = 32'hFFFF;
		endcase
		word = val & mask;
		if ($urandom_range(0, 1))
			word = word | ($urandom & ~mask);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		sb.set_reg(idx, word);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int deb, input int lng, input int tmo, input int wake,
			input bit do_wake);
		drain();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_LONG, lng);
		write_reg(REG_TIMEOUT, tmo);
		if (do_wake)
			write_reg(REG_WAKE, wake);
	endtask

	// Mostly whole press/release gestures around the thresholds, some level noise.
	task automatic random_gestures(input int stop_at);
		int span;
		while (items_sent < stop_at) begin
			span = sb.debounce + sb.long_thr + sb.timeout_thr + 3;
			if (span > 60)
				span = 60;
			if ($urandom_range(0, 99) < 75)
				press_release($urandom_range(1, span), $urandom_range(1, 4));
			else
				repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: start a press and sit in debounce
		send_level(1'b0);
		send_level(1'b1);
		send_level(1'b1);
		send_level(1'b0);

		// zero thresholds: accept on the edge, long and timeout on the first tick
		configure(0, 0, 0, 0, 1'b1);
		press_release(2, 1);
		press_release(2, 1);

		// start in wake-confirm: failed confirm, then confirmed power-on
		configure(0, 2, 3, 1, 1'b1);
		send_level(1'b0);
		press_release(5, 2);
		press_release(1, 1);
		press_release(3, 1);

		configure(2, 6, 12, 0, 1'b1);
		random_gestures(items_sent + 350);

		configure(0, 1, 1, 1, 1'b1);
		random_gestures(items_sent + 200);

		// long stretch with no idling on either side
		configure(5, 10, 4, 0, 1'b0);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		random_gestures(items_sent + 250);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		// widest debounce: accepted press that goes long, sleep, failed wake
		configure(255, 300, 65535, 0, 1'b1);
		send_level(1'b0);
		press_release(310, 2);
		press_release(5, 2);

		configure(1, 65535, 65535, 0, 1'b1);
		press_release(3, 1);
		press_release(20, 2);
		press_release(1, 2);

		while (items_sent < 1550) begin
			configure($urandom_range(0, 7), $urandom_range(0, 20), $urandom_range(0, 25),
				$urandom_range(0, 1), 1'($urandom_range(0, 1)));
			random_gestures(items_sent + 120);
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("power_key_press_classifier: match");
		else
			$display("power_key_press_classifier: mismatch");
		$finish;
	end

endmodule
